### sv/tvmu_pkg.sv
`default_nettype none
package tvmu_pkg;

   localparam int VALUE_WIDTH   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int MEAN_WIDTH    = 32;
   localparam int ITER_STAGES   = 32;

   localparam logic [2:0] CMD_GEOMETRIC  = 3'd1;
   localparam logic [2:0] CMD_WEIGHTED   = 3'd2;
   localparam logic [2:0] CMD_HARMONIC   = 3'd3;
   localparam logic [2:0] CMD_ARITHMETIC = 3'd4;

   typedef enum logic [1:0] {
      MODE_GEO,
      MODE_DIV,
      MODE_ZERO,
      MODE_BAD
   } mode_type;

   // One item in flight through the iteration stages.
   typedef struct packed {
      mode_type    mode;
      logic [31:0] num;   // low numerator bits, consumed from the top
      logic [33:0] den;
      logic [33:0] rem;
      logic [31:0] quo;
      logic [95:0] cub;   // radicand, consumed three bits per stage
      logic [31:0] root;
      logic [63:0] sq;    // root squared
      logic [69:0] crem;
   } iter_type;

endpackage
`default_nettype wire

### sv/three_value_mean_unit_core.sv
// Selectable mean of three unsigned 16-bit operands, result in unsigned Q16.16.
// Input channel req_*: operands and cmd (1 geometric, 2 weighted, 3 harmonic,
// 4 arithmetic); any other cmd returns zero with rsp_status set.
// Output channel rsp_*: one transaction per accepted input, in order.
// The path from acceptance to rsp_valid runs through the operand register, two
// multiply stages, a setup stage, 32 iteration stages and the output register.
// Each iteration stage resolves one result bit, either one quotient bit of a
// restoring divider or one bit of a digit-by-digit cube root, so a new item can
// enter every cycle and throughput is one transaction per cycle while the receiver does not stall.
// Each stage has its own valid bit and moves forward when the stage after it
// is empty or moving, so a stalled receiver only backs up the pipeline as far
// as it is full; bubbles are squeezed out and req_ready stays high until every
// stage holds an item. Synchronous reset clears all valid bits; nothing else
// is kept between items.
`default_nettype none
module three_value_mean_unit_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tvmu_pkg::VALUE_WIDTH-1:0]  req_first_value,
   input  wire logic [tvmu_pkg::VALUE_WIDTH-1:0]  req_second_value,
   input  wire logic [tvmu_pkg::VALUE_WIDTH-1:0]  req_third_value,
   input  wire logic [2:0]                        req_cmd,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [tvmu_pkg::MEAN_WIDTH-1:0]        rsp_mean_value,
   output logic                                   rsp_status
);
   import tvmu_pkg::*;

   function automatic iter_type iter_step(input iter_type cur);
      iter_type    nxt;
      logic [34:0] drr;
      logic [69:0] crr;
      logic [69:0] cand;
      nxt = cur;
      drr = {cur.rem, cur.num[31]};
      nxt.num = {cur.num[30:0], 1'b0};
      if (drr >= {1'b0, cur.den}) begin
         nxt.rem = 34'(drr - {1'b0, cur.den});
         nxt.quo = {cur.quo[30:0], 1'b1};
      end else begin
         nxt.rem = drr[33:0];
         nxt.quo = {cur.quo[30:0], 1'b0};
      end
      // (2y+1)^3 - (2y)^3 = 12y^2 + 6y + 1
      crr  = {cur.crem[66:0], cur.cub[95:93]};
      cand = {3'b0, cur.sq, 3'b0} + {4'b0, cur.sq, 2'b0} + {36'b0, cur.root, 2'b0}
           + {37'b0, cur.root, 1'b0} + 70'd1;
      nxt.cub = {cur.cub[92:0], 3'b0};
      if (crr >= cand) begin
         nxt.crem = crr - cand;
         nxt.root = {cur.root[30:0], 1'b1};
         nxt.sq   = {cur.sq[61:0], 2'b0} + {30'b0, cur.root[31:0], 2'b0} + 64'd1;
      end else begin
         nxt.crem = crr;
         nxt.root = {cur.root[30:0], 1'b0};
         nxt.sq   = {cur.sq[61:0], 2'b0};
      end
      return nxt;
   endfunction

   // Stage 1: operands
   logic        s1_v_ff;
   logic [15:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [2:0]  s1_cmd_ff;
   // Stage 2: pairwise products and linear sums
   logic        s2_v_ff;
   logic [31:0] s2_ab_ff, s2_bc_ff, s2_ca_ff;
   logic [15:0] s2_c_ff;
   logic [18:0] s2_w_ff;
   logic [17:0] s2_s_ff;
   logic [2:0]  s2_cmd_ff;
   // Stage 3: triple product and denominator
   logic        s3_v_ff;
   logic [47:0] s3_abc_ff;
   logic [33:0] s3_d_ff;
   logic [18:0] s3_w_ff;
   logic [17:0] s3_s_ff;
   logic [2:0]  s3_cmd_ff;

   logic     it_v_ff [0:ITER_STAGES];
   iter_type it_ff   [0:ITER_STAGES];
   logic     it_rdy  [0:ITER_STAGES];
   iter_type it_in   [0:ITER_STAGES];

   logic        rsp_valid_ff;
   logic [31:0] rsp_mean_ff;
   logic        rsp_status_ff;
   logic        out_rdy, s3_rdy, s2_rdy, s1_rdy;
   logic [31:0] mean_in;
   logic [65:0] numer;
   logic [49:0] abc3;

   always_comb begin
      out_rdy = !rsp_valid_ff || rsp_ready;
      it_rdy[ITER_STAGES] = !it_v_ff[ITER_STAGES] || out_rdy;
      for (int k = ITER_STAGES - 1; k >= 0; k--) begin
         it_rdy[k] = !it_v_ff[k] || it_rdy[k+1];
      end
      s3_rdy = !s3_v_ff || it_rdy[0];
      s2_rdy = !s2_v_ff || s3_rdy;
      s1_rdy = !s1_v_ff || s2_rdy;
   end

   assign req_ready = s1_rdy;

   // Set up the division or the cube root for the selected mean.
   always_comb begin
      abc3 = {1'b0, s3_abc_ff, 1'b0} + {2'b0, s3_abc_ff};
      numer = '0;
      it_in[0].mode = MODE_BAD;
      it_in[0].den  = '0;
      it_in[0].cub  = '0;
      case (s3_cmd_ff)
         CMD_GEOMETRIC: begin
            it_in[0].mode = MODE_GEO;
            it_in[0].cub  = {s3_abc_ff, 48'b0};
         end
         CMD_WEIGHTED: begin
            it_in[0].mode = MODE_DIV;
            numer = {31'b0, s3_w_ff, 16'b0};
            it_in[0].den = 34'd6;
         end
         CMD_HARMONIC: begin
            it_in[0].mode = (s3_d_ff == '0) ? MODE_ZERO : MODE_DIV;
            numer = {abc3, 16'b0};
            it_in[0].den = s3_d_ff;
         end
         CMD_ARITHMETIC: begin
            it_in[0].mode = MODE_DIV;
            numer = {32'b0, s3_s_ff, 16'b0};
            it_in[0].den = 34'd3;
         end
         default: begin
            it_in[0].mode = MODE_BAD;
         end
      endcase
      it_in[0].num  = numer[31:0];
      it_in[0].rem  = numer[65:32];
      it_in[0].quo  = '0;
      it_in[0].root = '0;
      it_in[0].sq   = '0;
      it_in[0].crem = '0;
      for (int k = 1; k <= ITER_STAGES; k++) begin
         it_in[k] = iter_step(it_ff[k-1]);
      end
   end

   always_comb begin
      case (it_ff[ITER_STAGES].mode)
         MODE_GEO: mean_in = it_ff[ITER_STAGES].root;
         MODE_DIV: mean_in = it_ff[ITER_STAGES].quo;
         default:  mean_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_a_ff   <= req_first_value;
         s1_b_ff   <= req_second_value;
         s1_c_ff   <= req_third_value;
         s1_cmd_ff <= req_cmd;
      end
      if (s2_rdy) begin
         s2_ab_ff  <= 32'(s1_a_ff * s1_b_ff);
         s2_bc_ff  <= 32'(s1_b_ff * s1_c_ff);
         s2_ca_ff  <= 32'(s1_c_ff * s1_a_ff);
         s2_c_ff   <= s1_c_ff;
         s2_w_ff   <= {3'b0, s1_a_ff} + {2'b0, s1_b_ff, 1'b0}
                    + {2'b0, s1_c_ff, 1'b0} + {3'b0, s1_c_ff};
         s2_s_ff   <= {2'b0, s1_a_ff} + {2'b0, s1_b_ff} + {2'b0, s1_c_ff};
         s2_cmd_ff <= s1_cmd_ff;
      end
      if (s3_rdy) begin
         s3_abc_ff <= 48'(s2_ab_ff * s2_c_ff);
         s3_d_ff   <= {2'b0, s2_ab_ff} + {2'b0, s2_bc_ff} + {2'b0, s2_ca_ff};
         s3_w_ff   <= s2_w_ff;
         s3_s_ff   <= s2_s_ff;
         s3_cmd_ff <= s2_cmd_ff;
      end
      for (int k = 0; k <= ITER_STAGES; k++) begin
         if (it_rdy[k]) begin
            it_ff[k] <= it_in[k];
         end
      end
      if (out_rdy) begin
         rsp_mean_ff   <= mean_in;
         rsp_status_ff <= (it_ff[ITER_STAGES].mode == MODE_BAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= ITER_STAGES; k++) begin
            it_v_ff[k] <= 1'b0;
         end
      end else begin
         if (s1_rdy) s1_v_ff <= req_valid;
         if (s2_rdy) s2_v_ff <= s1_v_ff;
         if (s3_rdy) s3_v_ff <= s2_v_ff;
         if (it_rdy[0]) it_v_ff[0] <= s3_v_ff;
         for (int k = 1; k <= ITER_STAGES; k++) begin
            if (it_rdy[k]) it_v_ff[k] <= it_v_ff[k-1];
         end
         if (out_rdy) rsp_valid_ff <= it_v_ff[ITER_STAGES];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = rsp_mean_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

### tb/sv/tvmu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tvmu_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [tvmu_pkg::VALUE_WIDTH-1:0]  req_first_value,
   input  wire logic [tvmu_pkg::VALUE_WIDTH-1:0]  req_second_value,
   input  wire logic [tvmu_pkg::VALUE_WIDTH-1:0]  req_third_value,
   input  wire logic [2:0]                        req_cmd,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [tvmu_pkg::MEAN_WIDTH-1:0]   rsp_mean_value,
   input  wire logic                              rsp_status,
   output int                                     error_count,
   output int                                     pending_count,
   output int                                     mean_count
);
   import tvmu_pkg::*;

   typedef struct {
      logic [31:0] mean;
      logic        status;
   } mean_result_type;

   mean_result_type expected_means[$];

   // Largest q below 2^32 with q*den <= num; zero for a zero divisor.
   function automatic logic [31:0] divide_floor(logic [127:0] num, logic [127:0] den);
      logic [31:0] q;
      logic [31:0] t;
      q = '0;
      if (den == 0) return '0;
      for (int i = 31; i >= 0; i--) begin
         t = q | (32'd1 << i);
         if (den * t <= num) q = t;
      end
      return q;
   endfunction

   function automatic logic [31:0] cube_root_floor(logic [127:0] rad);
      logic [31:0]  r;
      logic [31:0]  t;
      logic [127:0] w;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (32'd1 << i);
         w = 128'(t);
         if (w * w * w <= rad) r = t;
      end
      return r;
   endfunction

   function automatic mean_result_type compute_mean(logic [15:0] a, logic [15:0] b,
                                                    logic [15:0] c, logic [2:0] cmd);
      mean_result_type res;
      logic [127:0] av, bv, cv;
      av = 128'(a);
      bv = 128'(b);
      cv = 128'(c);
      res.mean = '0;
      res.status = 1'b0;
      case (cmd)
         CMD_GEOMETRIC: begin
            res.mean = cube_root_floor((av * bv * cv) << (3 * FRACTION_BITS));
         end
         CMD_WEIGHTED: begin
            res.mean = divide_floor((av + 2 * bv + 3 * cv) << FRACTION_BITS, 128'd6);
         end
         CMD_HARMONIC: begin
            res.mean = divide_floor((3 * av * bv * cv) << FRACTION_BITS,
                                    av * bv + bv * cv + cv * av);
         end
         CMD_ARITHMETIC: begin
            res.mean = divide_floor((av + bv + cv) << FRACTION_BITS, 128'd3);
         end
         default: begin
            res.status = 1'b1;
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      error_count++;
   endtask

   assign pending_count = expected_means.size();

   always @(posedge clock) begin
      mean_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_means.push_back(compute_mean(req_first_value, req_second_value,
                                                  req_third_value, req_cmd));
         end
         if (rsp_valid && rsp_ready) begin
            mean_count++;
            if (expected_means.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = expected_means.pop_front();
               if (rsp_mean_value !== want.mean)
                  report_mismatch($sformatf("mean_value got %h want %h",
                                            rsp_mean_value, want.mean));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %b want %b",
                                            rsp_status, want.status));
            end
         end
      end
   end
endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import tvmu_pkg::*;

   localparam int RANDOM_ITEMS = 1130;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_first_value;
   logic [15:0] req_second_value;
   logic [15:0] req_third_value;
   logic [2:0]  req_cmd;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_mean_value;
   logic        rsp_status;
   int          error_count;
   int          pending_count;
   int          mean_count;
   int          sent_count;

   three_value_mean_unit_core u_dut (.*);

   tvmu_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver alternates between open stretches and random stall patterns.
   initial begin
      int mode;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   task automatic send_mean_request(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                    logic [2:0] cmd);
      req_valid <= 1'b1;
      req_first_value <= a;
      req_second_value <= b;
      req_third_value <= c;
      req_cmd <= cmd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 16'(16'hFFFF - $urandom_range(0, 3));
         1: return 16'($urandom_range(0, 3));
         2: return 16'd1 << $urandom_range(0, 15);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_cmd();
      if ($urandom_range(0, 9) == 0) return 3'($urandom);
      case ($urandom_range(0, 3))
         0: return CMD_GEOMETRIC;
         1: return CMD_WEIGHTED;
         2: return CMD_HARMONIC;
         default: return CMD_ARITHMETIC;
      endcase
   endfunction

   initial begin
      req_valid = 1'b0;
      req_first_value = '0;
      req_second_value = '0;
      req_third_value = '0;
      req_cmd = '0;
      reset = 1'b1;
      sent_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int k = 0; k < 8; k++) begin
         send_mean_request(16'hFFFF, 16'hFFFF, 16'hFFFF, k[2:0]);
         send_mean_request(16'd1, 16'd1, 16'd1, k[2:0]);
      end
      send_mean_request(16'd0, 16'd0, 16'd0, CMD_HARMONIC);
      send_mean_request(16'd0, 16'd5, 16'd7, CMD_HARMONIC);
      send_mean_request(16'd0, 16'd5, 16'd7, CMD_GEOMETRIC);
      send_mean_request(16'd0, 16'd0, 16'hFFFF, CMD_WEIGHTED);
      send_mean_request(16'hFFFF, 16'd0, 16'd0, CMD_ARITHMETIC);
      send_mean_request(16'd1, 16'hFFFF, 16'd1, CMD_HARMONIC);
      req_valid <= 1'b0;
      @(posedge clock);
      // Let the pipeline drain completely before the random traffic.
      while (pending_count != 0) @(posedge clock);
      while (sent_count < RANDOM_ITEMS + 22) begin
         repeat ($urandom_range(1, 60)) begin
            send_mean_request(pick_operand(), pick_operand(), pick_operand(), pick_cmd());
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d requests over all mean kinds and invalid selectors,", sent_count);
      $display("with %0d results checked under random stalls on both sides.", mean_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
